/* src/ppc_pkg.sv */
// shared types, widths and helpers for the point plane classifier
`default_nettype none

package ppc_pkg;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_NORMAL_A     = 3'd0;
    localparam logic [2:0] REG_NORMAL_B     = 3'd1;
    localparam logic [2:0] REG_NORMAL_C     = 3'd2;
    localparam logic [2:0] REG_PLANE_OFFSET = 3'd3;
    localparam logic [2:0] REG_DIST_SCALE   = 3'd4;
    localparam logic [2:0] REG_INLIER_THR   = 3'd5;
    localparam logic [2:0] REG_PLANE_VALID  = 3'd6;

    // field widths
    localparam int COEF_W   = 18;
    localparam int COORD_W  = 32;
    localparam int SCALE_W  = 22;
    localparam int THR_W    = 31;
    localparam int COEF_FRAC = 16;

    // reset values
    localparam logic [COEF_W-1:0]  NORMAL_C_RST = 18'd65536;
    localparam logic [SCALE_W-1:0] SCALE_RST    = 22'd65536;
    localparam logic [THR_W-1:0]   THR_RST      = 31'd6554;

    // projection is skipped for points this close to the plane
    localparam int SNAP_DISTANCE = 66;
    localparam int ROUND_HALF    = 1 << (COEF_FRAC - 1);

    // datapath widths
    localparam int MUL_W = COEF_W + COORD_W;        // one coefficient product
    localparam int SUM_W = MUL_W + 2;               // sum of three products and offset
    localparam int T_W   = SUM_W - COEF_FRAC;       // sum after the coefficient shift
    localparam int SP_W  = T_W + SCALE_W + 1;       // scaled distance before shift
    localparam int D_W   = SP_W - COEF_FRAC;        // distance
    localparam int PN_W  = D_W + COEF_W + 1;        // distance times normal
    localparam int PS_W  = PN_W - COEF_FRAC;        // projection offset
    localparam int SAT_W = PS_W + 1;                // projected coordinate before saturation

    typedef struct packed {
        logic [COEF_W-1:0]  normal_a;
        logic [COEF_W-1:0]  normal_b;
        logic [COEF_W-1:0]  normal_c;
        logic [COORD_W-1:0] plane_offset;
        logic [SCALE_W-1:0] distance_scale;
        logic [THR_W-1:0]   inlier_threshold;
        logic               plane_valid;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    function automatic logic signed [COORD_W-1:0] sat_s32(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-COORD_W:0] top_bits;
        top_bits = v[SAT_W-1:COORD_W-1];
        if (top_bits == '0 || top_bits == '1) begin
            return v[COORD_W-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

/* src/ppc_cfg.sv */
// configuration register file behind the apb port
`default_nettype none

module ppc_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ppc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [ppc_pkg::DATA_W-1:0]    pwdata,
    output logic      [ppc_pkg::DATA_W-1:0]    prdata,
    output ppc_pkg::cfg_t                      cfg
);

    ppc_pkg::cfg_t cfg_reg;
    ppc_pkg::cfg_t cfg_next;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[ppc_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                ppc_pkg::REG_NORMAL_A:     cfg_next.normal_a = pwdata[ppc_pkg::COEF_W-1:0];
                ppc_pkg::REG_NORMAL_B:     cfg_next.normal_b = pwdata[ppc_pkg::COEF_W-1:0];
                ppc_pkg::REG_NORMAL_C:     cfg_next.normal_c = pwdata[ppc_pkg::COEF_W-1:0];
                ppc_pkg::REG_PLANE_OFFSET: cfg_next.plane_offset = pwdata;
                ppc_pkg::REG_DIST_SCALE:   cfg_next.distance_scale = pwdata[ppc_pkg::SCALE_W-1:0];
                ppc_pkg::REG_INLIER_THR:   cfg_next.inlier_threshold = pwdata[ppc_pkg::THR_W-1:0];
                ppc_pkg::REG_PLANE_VALID:  cfg_next.plane_valid = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.normal_a         <= '0;
            cfg_reg.normal_b         <= '0;
            cfg_reg.normal_c         <= ppc_pkg::NORMAL_C_RST;
            cfg_reg.plane_offset     <= '0;
            cfg_reg.distance_scale   <= ppc_pkg::SCALE_RST;
            cfg_reg.inlier_threshold <= ppc_pkg::THR_RST;
            cfg_reg.plane_valid      <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            ppc_pkg::REG_NORMAL_A:     prdata = ppc_pkg::DATA_W'(cfg_reg.normal_a);
            ppc_pkg::REG_NORMAL_B:     prdata = ppc_pkg::DATA_W'(cfg_reg.normal_b);
            ppc_pkg::REG_NORMAL_C:     prdata = ppc_pkg::DATA_W'(cfg_reg.normal_c);
            ppc_pkg::REG_PLANE_OFFSET: prdata = cfg_reg.plane_offset;
            ppc_pkg::REG_DIST_SCALE:   prdata = ppc_pkg::DATA_W'(cfg_reg.distance_scale);
            ppc_pkg::REG_INLIER_THR:   prdata = ppc_pkg::DATA_W'(cfg_reg.inlier_threshold);
            ppc_pkg::REG_PLANE_VALID:  prdata = ppc_pkg::DATA_W'(cfg_reg.plane_valid);
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/point_plane_classifier.sv */
// Point to plane classifier. Each point (Q16.16) is checked against the plane
// a*x + b*y + c*z + d = 0 set over the apb port: the block returns the scaled
// signed distance, its magnitude, inlier and above-plane flags and the
// projection onto the plane; distance and projection saturate to 32 bits,
// the magnitude to 31 bits. A five-stage pipeline (coefficient products, sum,
// scale multiply, normal multiplies, projection and saturation) takes one
// point every cycle while the output side does not stall.
// Registers should only be written while no points are in flight. With
// plane_valid cleared every result carries no_plane and zero fields.
`default_nettype none

module point_plane_classifier #(
    parameter int SNAP_DISTANCE = ppc_pkg::SNAP_DISTANCE
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic        [ppc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic        [ppc_pkg::DATA_W-1:0]  pwdata,
    output logic             [ppc_pkg::DATA_W-1:0]  prdata,
    output logic                                    pready,
    // points in
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [ppc_pkg::COORD_W-1:0] s_point_x,
    input  wire logic signed [ppc_pkg::COORD_W-1:0] s_point_y,
    input  wire logic signed [ppc_pkg::COORD_W-1:0] s_point_z,
    // results out
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed      [ppc_pkg::COORD_W-1:0] m_signed_distance,
    output logic             [ppc_pkg::THR_W-1:0]   m_abs_distance,
    output logic                                    m_is_inlier,
    output logic                                    m_is_above,
    output logic signed      [ppc_pkg::COORD_W-1:0] m_proj_x,
    output logic signed      [ppc_pkg::COORD_W-1:0] m_proj_y,
    output logic signed      [ppc_pkg::COORD_W-1:0] m_proj_z,
    output logic                                    m_no_plane
);

    localparam int COORD_W = ppc_pkg::COORD_W;
    localparam int COEF_W  = ppc_pkg::COEF_W;
    localparam int MUL_W   = ppc_pkg::MUL_W;
    localparam int SUM_W   = ppc_pkg::SUM_W;
    localparam int T_W     = ppc_pkg::T_W;
    localparam int SP_W    = ppc_pkg::SP_W;
    localparam int D_W     = ppc_pkg::D_W;
    localparam int PN_W    = ppc_pkg::PN_W;
    localparam int PS_W    = ppc_pkg::PS_W;
    localparam int SAT_W   = ppc_pkg::SAT_W;
    localparam int THR_W   = ppc_pkg::THR_W;
    localparam int FRAC    = ppc_pkg::COEF_FRAC;

    ppc_pkg::cfg_t cfg;

    ppc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    logic signed [COEF_W-1:0]  na, nb, nc;
    logic signed [COORD_W-1:0] offset;
    logic signed [ppc_pkg::SCALE_W:0] scale;

    assign na     = $signed(cfg.normal_a);
    assign nb     = $signed(cfg.normal_b);
    assign nc     = $signed(cfg.normal_c);
    assign offset = $signed(cfg.plane_offset);
    assign scale  = $signed({1'b0, cfg.distance_scale});

    // stall control: a stage loads when empty or when the next one loads
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5    = !v5_reg || m_ready;
    assign adv4    = !v4_reg || adv5;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;
    assign m_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    // stage 1: coefficient products
    ppc_pkg::point_t          p1_reg;
    logic signed [MUL_W-1:0]  ma_reg, mb_reg, mc_reg;
    logic signed [MUL_W-1:0]  ma_next, mb_next, mc_next;

    assign ma_next = MUL_W'(na) * MUL_W'(s_point_x);
    assign mb_next = MUL_W'(nb) * MUL_W'(s_point_y);
    assign mc_next = MUL_W'(nc) * MUL_W'(s_point_z);

    always_ff @(posedge aclk) begin
        if (adv1) begin
            p1_reg.x <= s_point_x;
            p1_reg.y <= s_point_y;
            p1_reg.z <= s_point_z;
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            mc_reg   <= mc_next;
        end
    end

    // stage 2: plane sum and side of plane
    ppc_pkg::point_t          p2_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [T_W-1:0]    t_reg;
    logic                     above2_reg, above2_next;
    logic                     c_pos, c_neg;

    assign sum_next = SUM_W'(ma_reg) + SUM_W'(mb_reg) + SUM_W'(mc_reg)
                    + SUM_W'($signed({offset, {FRAC{1'b0}}}));
    assign c_neg    = nc[COEF_W-1];
    assign c_pos    = !c_neg && (nc != '0);

    always_comb begin
        if (c_pos) begin
            above2_next = !sum_next[SUM_W-1];
        end else if (c_neg) begin
            above2_next = sum_next[SUM_W-1] || (sum_next == '0);
        end else begin
            above2_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            p2_reg     <= p1_reg;
            t_reg      <= $signed(sum_next[SUM_W-1:FRAC]);
            above2_reg <= above2_next;
        end
    end

    // stage 3: scale by reciprocal normal length, round half up
    ppc_pkg::point_t        p3_reg;
    logic signed [SP_W-1:0] sp_reg, sp_next;
    logic                   above3_reg;

    assign sp_next = SP_W'(t_reg) * SP_W'(scale) + SP_W'(ppc_pkg::ROUND_HALF);

    always_ff @(posedge aclk) begin
        if (adv3) begin
            p3_reg     <= p2_reg;
            sp_reg     <= sp_next;
            above3_reg <= above2_reg;
        end
    end

    // stage 4: distance magnitude, flags and distance times normal
    ppc_pkg::point_t        p4_reg;
    logic signed [D_W-1:0]  dist3;
    logic        [D_W-1:0]  mag3;
    logic signed [D_W-1:0]  d4_reg;
    logic        [D_W-1:0]  mag4_reg;
    logic                   inlier4_reg, snap4_reg, above4_reg;
    logic signed [PN_W-1:0] pna_reg, pnb_reg, pnc_reg;

    assign dist3 = $signed(sp_reg[SP_W-1:FRAC]);
    assign mag3  = dist3[D_W-1] ? D_W'(-dist3) : D_W'(dist3);

    always_ff @(posedge aclk) begin
        if (adv4) begin
            p4_reg      <= p3_reg;
            d4_reg      <= dist3;
            mag4_reg    <= mag3;
            inlier4_reg <= mag3 <= D_W'(cfg.inlier_threshold);
            snap4_reg   <= mag3 <= D_W'(SNAP_DISTANCE);
            above4_reg  <= above3_reg;
            pna_reg     <= PN_W'(dist3) * PN_W'(na) + PN_W'(ppc_pkg::ROUND_HALF);
            pnb_reg     <= PN_W'(dist3) * PN_W'(nb) + PN_W'(ppc_pkg::ROUND_HALF);
            pnc_reg     <= PN_W'(dist3) * PN_W'(nc) + PN_W'(ppc_pkg::ROUND_HALF);
        end
    end

    // stage 5: projection, saturation and output register
    logic signed [SAT_W-1:0]   dx, dy, dz;
    logic signed [COORD_W-1:0] px_next, py_next, pz_next;
    logic [THR_W-1:0]          abs_next;

    assign dx = SAT_W'(p4_reg.x) - SAT_W'($signed(pna_reg[PN_W-1:FRAC]));
    assign dy = SAT_W'(p4_reg.y) - SAT_W'($signed(pnb_reg[PN_W-1:FRAC]));
    assign dz = SAT_W'(p4_reg.z) - SAT_W'($signed(pnc_reg[PN_W-1:FRAC]));

    assign px_next  = snap4_reg ? p4_reg.x : ppc_pkg::sat_s32(dx);
    assign py_next  = snap4_reg ? p4_reg.y : ppc_pkg::sat_s32(dy);
    assign pz_next  = snap4_reg ? p4_reg.z : ppc_pkg::sat_s32(dz);
    assign abs_next = (mag4_reg > D_W'({THR_W{1'b1}})) ? {THR_W{1'b1}} : mag4_reg[THR_W-1:0];

    always_ff @(posedge aclk) begin
        if (adv5) begin
            if (cfg.plane_valid) begin
                m_signed_distance <= ppc_pkg::sat_s32(SAT_W'(d4_reg));
                m_abs_distance    <= abs_next;
                m_is_inlier       <= inlier4_reg;
                m_is_above        <= above4_reg;
                m_proj_x          <= px_next;
                m_proj_y          <= py_next;
                m_proj_z          <= pz_next;
                m_no_plane        <= 1'b0;
            end else begin
                m_signed_distance <= '0;
                m_abs_distance    <= '0;
                m_is_inlier       <= 1'b0;
                m_is_above        <= 1'b0;
                m_proj_x          <= '0;
                m_proj_y          <= '0;
                m_proj_z          <= '0;
                m_no_plane        <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* verif/point_plane_classifier_tb.sv */
// testbench for the point plane classifier: directed and random points against a plane predictor
`timescale 1ns / 1ps

module point_plane_classifier_tb;

    import ppc_pkg::*;

    localparam int      RESET_CYCLES   = 7;
    localparam int      RANDOM_ITEMS   = 500;
    localparam int      DRAIN_CYCLES   = 8;
    localparam int      END_CYCLES     = 20;
    localparam int      WATCHDOG_LIMIT = 1000;
    localparam int      FRAC           = 16;
    localparam longint  HALF_LSB       = 64'sd32768;
    localparam longint  SNAP_LIMIT     = 64'sd66;
    localparam longint  WORD_MAX       = 64'sd2147483647;
    localparam longint  WORD_MIN       = -64'sd2147483648;
    localparam logic [2:0] REG_UNUSED  = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] signed_distance;
        logic        [THR_W-1:0]   abs_distance;
        logic                      is_inlier;
        logic                      is_above;
        logic signed [COORD_W-1:0] proj_x;
        logic signed [COORD_W-1:0] proj_y;
        logic signed [COORD_W-1:0] proj_z;
        logic                      no_plane;
    } plane_result_t;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_POINT,
        STEP_KNOWN
    } step_kind_e;

    typedef struct {
        step_kind_e         kind;
        logic [2:0]         reg_idx;
        logic [31:0]        wdata;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        plane_result_t      want;
    } stim_step_t;

    localparam plane_result_t NO_PLANE_RES = '{no_plane: 1'b1, default: '0};

    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [ADDR_W-1:0]         paddr   = '0;
    logic [DATA_W-1:0]         pwdata  = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_point_x = '0;
    logic signed [COORD_W-1:0] s_point_y = '0;
    logic signed [COORD_W-1:0] s_point_z = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [COORD_W-1:0] m_signed_distance;
    logic        [THR_W-1:0]   m_abs_distance;
    logic                      m_is_inlier;
    logic                      m_is_above;
    logic signed [COORD_W-1:0] m_proj_x;
    logic signed [COORD_W-1:0] m_proj_y;
    logic signed [COORD_W-1:0] m_proj_z;
    logic                      m_no_plane;

    // shadow copy of the plane registers
    longint cfg_a, cfg_b, cfg_c, cfg_offset, cfg_scale, cfg_thr;
    bit     cfg_valid;
    bit     plane_is_axis;

    plane_result_t due_results[$];
    stim_step_t    stim_rows[$];
    int            err_count   = 0;
    int            burst_left  = 0;
    bit            dirty       = 1'b0;
    int            ready_left  = 0;
    int            ready_mode  = 0;
    int            quiet_count = 0;

    string field_names[8] = '{"signed_distance", "abs_distance", "is_inlier", "is_above",
                              "proj_x", "proj_y", "proj_z", "no_plane"};

    point_plane_classifier u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_point_x         (s_point_x),
        .s_point_y         (s_point_y),
        .s_point_z         (s_point_z),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_signed_distance (m_signed_distance),
        .m_abs_distance    (m_abs_distance),
        .m_is_inlier       (m_is_inlier),
        .m_is_above        (m_is_above),
        .m_proj_x          (m_proj_x),
        .m_proj_y          (m_proj_y),
        .m_proj_z          (m_proj_z),
        .m_no_plane        (m_no_plane)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void shadow_write(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_NORMAL_A:     cfg_a      = longint'($signed(data[COEF_W-1:0]));
            REG_NORMAL_B:     cfg_b      = longint'($signed(data[COEF_W-1:0]));
            REG_NORMAL_C:     cfg_c      = longint'($signed(data[COEF_W-1:0]));
            REG_PLANE_OFFSET: cfg_offset = longint'($signed(data));
            REG_DIST_SCALE:   cfg_scale  = longint'(data[SCALE_W-1:0]);
            REG_INLIER_THR:   cfg_thr    = longint'(data[THR_W-1:0]);
            REG_PLANE_VALID:  cfg_valid  = data[0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] clamp_word(input longint v);
        if (v > WORD_MAX) begin
            return 32'h7FFF_FFFF;
        end else if (v < WORD_MIN) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // distance, flags and projection of one point against the shadow plane
    function automatic plane_result_t plane_result(input logic signed [31:0] px,
                                                   input logic signed [31:0] py,
                                                   input logic signed [31:0] pz);
        longint        pt[3];
        longint        nv[3];
        longint        sum, tq, dist_val, mag, moved;
        logic [31:0]   pj[3];
        plane_result_t r;
        r = '0;
        if (!cfg_valid) begin
            r.no_plane = 1'b1;
            return r;
        end
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        nv[0] = cfg_a;
        nv[1] = cfg_b;
        nv[2] = cfg_c;
        sum      = nv[0] * pt[0] + nv[1] * pt[1] + nv[2] * pt[2] + cfg_offset * 65536;
        tq       = sum >>> FRAC;
        dist_val = (tq * cfg_scale + HALF_LSB) >>> FRAC;
        mag      = (dist_val < 0) ? -dist_val : dist_val;
        r.signed_distance = clamp_word(dist_val);
        r.abs_distance    = (mag > WORD_MAX) ? 31'h7FFF_FFFF : mag[30:0];
        r.is_inlier       = (mag <= cfg_thr);
        if (cfg_c > 0) begin
            r.is_above = (sum >= 0);
        end else if (cfg_c < 0) begin
            r.is_above = (sum <= 0);
        end else begin
            r.is_above = 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            if (mag <= SNAP_LIMIT) begin
                moved = pt[i];
            end else begin
                moved = pt[i] - ((dist_val * nv[i] + HALF_LSB) >>> FRAC);
            end
            pj[i] = clamp_word(moved);
        end
        r.proj_x = pj[0];
        r.proj_y = pj[1];
        r.proj_z = pj[2];
        return r;
    endfunction

    function automatic logic [31:0] field_word(input plane_result_t r, input int f);
        case (f)
            0:       return r.signed_distance;
            1:       return 32'(r.abs_distance);
            2:       return 32'(r.is_inlier);
            3:       return 32'(r.is_above);
            4:       return r.proj_x;
            5:       return r.proj_y;
            6:       return r.proj_z;
            default: return 32'(r.no_plane);
        endcase
    endfunction

    function automatic plane_result_t known_fields(input logic [31:0] sd, input logic [30:0] ad,
                                                   input bit inl, input bit abv,
                                                   input logic [31:0] px, input logic [31:0] py,
                                                   input logic [31:0] pz);
        return '{sd, ad, inl, abv, px, py, pz, 1'b0};
    endfunction

    function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] data);
        stim_step_t s;
        s.kind    = STEP_CFG;
        s.reg_idx = idx;
        s.wdata   = data;
        s.px      = '0;
        s.py      = '0;
        s.pz      = '0;
        s.want    = '0;
        stim_rows.insert(stim_rows.size(), s);
    endfunction

    function automatic void add_point(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z);
        stim_step_t s;
        s.kind    = STEP_POINT;
        s.reg_idx = '0;
        s.wdata   = '0;
        s.px      = x;
        s.py      = y;
        s.pz      = z;
        s.want    = '0;
        stim_rows.insert(stim_rows.size(), s);
    endfunction

    function automatic void add_known(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input plane_result_t want);
        stim_step_t s;
        s.kind    = STEP_KNOWN;
        s.reg_idx = '0;
        s.wdata   = '0;
        s.px      = x;
        s.py      = y;
        s.pz      = z;
        s.want    = want;
        stim_rows.insert(stim_rows.size(), s);
    endfunction

    // sign-extended random value of the given bit count
    function automatic int span_rand(input int bits);
        int v;
        v = $urandom();
        return v >>> (32 - bits);
    endfunction

    // fill the bits above the register width with noise
    function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
        logic [31:0] mask;
        if (w >= 32) begin
            return v;
        end
        mask = (32'h1 << w) - 32'h1;
        return (v & mask) | ($urandom() & ~mask);
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return 32'hFFFE_0000;
            1:       return 32'h0001_FFFF;
            2:       return 32'h0;
            3:       return 32'h0001_0000;
            4:       return 32'hFFFF_0000;
            default: return int'($urandom_range(0, 131072)) - 65536;
        endcase
    endfunction

    function automatic logic [31:0] corner_coord();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h1;
        endcase
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_write(idx, data);
        @(posedge aclk);
    endtask

    // let every point in flight come out before touching the registers
    task automatic settle_block();
        if (!dirty) begin
            return;
        end
        s_valid <= 1'b0;
        while (due_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        dirty = 1'b0;
    endtask

    task automatic push_point(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z, input plane_result_t want);
        int gap;
        bit took;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_point_x <= x;
        s_point_y <= y;
        s_point_z <= z;
        // ready is stable at the falling edge, so the transfer is known before the rising one
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        due_results.insert(due_results.size(), want);
        dirty = 1'b1;
    endtask

    task automatic load_random_plane();
        logic [31:0] a, b, c, off, scl, thr;
        bit          axis;
        axis = $urandom_range(0, 1);
        if (axis) begin
            // horizontal plane: distance is d plus or minus z, easy to land near
            a   = '0;
            b   = '0;
            c   = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            off = span_rand(31);
            scl = 32'h0001_0000;
            thr = $urandom_range(0, 20000);
        end else begin
            a   = rand_coef();
            b   = rand_coef();
            c   = rand_coef();
            off = $urandom_range(0, 1) ? $urandom() : span_rand(11);
            case ($urandom_range(0, 5))
                0:       scl = 32'h0001_0000;
                1:       scl = 32'h0;
                2:       scl = 32'h003F_FFFF;
                3, 4:    scl = $urandom_range(60000, 70000);
                default: scl = $urandom_range(0, 32'h003F_FFFF);
            endcase
            case ($urandom_range(0, 5))
                0:       thr = 32'h0;
                1:       thr = 32'h7FFF_FFFF;
                2, 3:    thr = $urandom_range(0, 100000);
                default: thr = $urandom() & 32'h7FFF_FFFF;
            endcase
        end
        apb_write(REG_NORMAL_A,     with_junk(a, COEF_W));
        apb_write(REG_NORMAL_B,     with_junk(b, COEF_W));
        apb_write(REG_NORMAL_C,     with_junk(c, COEF_W));
        apb_write(REG_PLANE_OFFSET, off);
        apb_write(REG_DIST_SCALE,   with_junk(scl, SCALE_W));
        apb_write(REG_INLIER_THR,   with_junk(thr, THR_W));
        apb_write(REG_PLANE_VALID,  with_junk({31'b0, $urandom_range(0, 7) != 0}, 1));
        plane_is_axis = axis;
    endtask

    task automatic gen_point(output logic signed [31:0] x, output logic signed [31:0] y,
                             output logic signed [31:0] z);
        longint near_z;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                x = $urandom();
                y = $urandom();
                z = $urandom();
            end
            3, 4: begin
                x = span_rand(21);
                y = span_rand(21);
                z = span_rand(21);
            end
            5: begin
                x = span_rand(7);
                y = span_rand(7);
                z = span_rand(7);
            end
            6: begin
                x = corner_coord();
                y = corner_coord();
                z = corner_coord();
            end
            default: begin
                if (plane_is_axis) begin
                    near_z = ((cfg_c > 0) ? -cfg_offset : cfg_offset) + span_rand(9);
                    x = $urandom();
                    y = $urandom();
                    z = near_z[31:0];
                end else begin
                    x = span_rand(7);
                    y = span_rand(7);
                    z = span_rand(7);
                end
            end
        endcase
    endtask

    // result side stalls in segments: always ready, coin flip, or held off
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(1, 30);
        end else begin
            ready_left--;
        end
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(0, 1);
            default: m_ready <= 1'b0;
        endcase
    end

    always @(negedge aclk) begin : check_results
        plane_result_t want;
        plane_result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_signed_distance, m_abs_distance, m_is_inlier, m_is_above,
                     m_proj_x, m_proj_y, m_proj_z, m_no_plane};
            if (due_results.size() == 0) begin
                err_count++;
                $display("%0t: result transfer with nothing expected, signed_distance %h",
                         $time, seen.signed_distance);
            end else begin
                want = due_results.pop_front();
                for (int f = 0; f < 8; f++) begin
                    if (field_word(want, f) !== field_word(seen, f)) begin
                        err_count++;
                        $display("%0t: %s expected %h, got %h", $time, field_names[f],
                                 field_word(want, f), field_word(seen, f));
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_count = 0;
            end else begin
                quiet_count++;
            end
            if (quiet_count >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_count);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int                 total;
        int                 n;
        logic signed [31:0] x, y, z;

        shadow_write(REG_NORMAL_A, 32'h0);
        shadow_write(REG_NORMAL_B, 32'h0);
        shadow_write(REG_NORMAL_C, 32'(NORMAL_C_RST));
        shadow_write(REG_PLANE_OFFSET, 32'h0);
        shadow_write(REG_DIST_SCALE, 32'(SCALE_RST));
        shadow_write(REG_INLIER_THR, 32'(THR_RST));
        shadow_write(REG_PLANE_VALID, 32'h0);
        plane_is_axis = 1'b0;

        // no plane after reset
        add_known(32'h0, 32'h0, 32'h0, NO_PLANE_RES);
        add_known(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, NO_PLANE_RES);
        // reset plane z = 0, enable bit written with noise above it
        add_cfg(REG_PLANE_VALID, 32'hFFFF_FFFF);
        add_known(32'h0, 32'h0, 32'h0, known_fields(0, 0, 1, 1, 0, 0, 0));
        add_known(32'h0, 32'h0, 32'h1_0000,
                  known_fields(32'h1_0000, 31'h1_0000, 0, 1, 0, 0, 0));
        // right at the snap distance the point stays where it is
        add_known(5, 7, -66, known_fields(-66, 66, 1, 0, 5, 7, -66));
        add_point(1, 2, -67);
        add_known(32'h0, 32'h0, 32'h7FFF_FFFF,
                  known_fields(32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 1, 0, 0, 0));
        add_known(32'h0, 32'h0, 32'h8000_0000,
                  known_fields(32'h8000_0000, 31'h7FFF_FFFF, 0, 0, 0, 0, 0));
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        // vertical plane: no above
        add_cfg(REG_NORMAL_C, 32'h0);
        add_point(123456, -98765, 4000000);
        // extreme coefficients and registers, noise in the unused bits
        add_cfg(REG_NORMAL_A, 32'hFFFE_0000);
        add_cfg(REG_NORMAL_B, 32'hABC1_FFFF);
        add_cfg(REG_NORMAL_C, 32'hFFFF_0000);
        add_cfg(REG_PLANE_OFFSET, 32'h8000_0000);
        add_cfg(REG_DIST_SCALE, 32'hFFFF_FFFF);
        add_cfg(REG_INLIER_THR, 32'hFFFF_FFFF);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        add_point(32'h0, 32'h0, 32'h0);
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // zero scale: everything is on the plane
        add_cfg(REG_DIST_SCALE, 32'h0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_point(12345, -6789, 100);
        add_cfg(REG_INLIER_THR, 32'h0);
        add_cfg(REG_DIST_SCALE, 32'h1_0000);
        add_point(32'h0, 32'h0, 32'h0);
        // a write past the last register must not reach the enable bit
        add_cfg(REG_PLANE_VALID, 32'h0);
        add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
        add_known(32'h1, 32'h1, 32'h1, NO_PLANE_RES);
        // plane z = -1 with zero threshold
        add_cfg(REG_PLANE_VALID, 32'h1);
        add_cfg(REG_NORMAL_A, 32'h0);
        add_cfg(REG_NORMAL_B, 32'h0);
        add_cfg(REG_NORMAL_C, 32'h1_0000);
        add_cfg(REG_PLANE_OFFSET, 32'h1_0000);
        add_known(32'h0, 32'h0, 32'hFFFF_0000, known_fields(0, 0, 1, 1, 0, 0, 32'hFFFF_0000));
        add_point(32'h0, 32'h0, 32'hFFFF_0043);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[k]) begin
            case (stim_rows[k].kind)
                STEP_CFG: begin
                    settle_block();
                    apb_write(stim_rows[k].reg_idx, stim_rows[k].wdata);
                end
                STEP_POINT: begin
                    push_point(stim_rows[k].px, stim_rows[k].py, stim_rows[k].pz,
                               plane_result(stim_rows[k].px, stim_rows[k].py,
                                            stim_rows[k].pz));
                end
                default: begin
                    push_point(stim_rows[k].px, stim_rows[k].py, stim_rows[k].pz,
                               stim_rows[k].want);
                end
            endcase
        end

        total = 0;
        while (total < RANDOM_ITEMS) begin
            settle_block();
            load_random_plane();
            n = $urandom_range(15, 60);
            repeat (n) begin
                gen_point(x, y, z);
                push_point(x, y, z, plane_result(x, y, z));
            end
            total += n;
        end

        settle_block();
        repeat (END_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/ppc_pkg.sv
src/ppc_cfg.sv
src/point_plane_classifier.sv
verif/point_plane_classifier_tb.sv
